/* design/slla_pkg.sv */
// Shared types, constants and command/status bundles for the sprite link-list allocator.
package slla_pkg;

  localparam int TABLE_ENTRIES_DEF = 80;
  localparam int LINK_W  = 7;
  localparam int POS_W   = 16;
  localparam int ATTR_W  = 16;
  localparam int SIZE_W  = 4;
  localparam int DELTA_W = 8;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_DROP    = 2'd1,
    OP_HSCROLL = 2'd2,
    OP_VSCROLL = 2'd3
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [LINK_W-1:0]         entry_index;
    logic signed [POS_W-1:0]   new_pos_x;
    logic signed [POS_W-1:0]   new_pos_y;
    logic [ATTR_W-1:0]         sprite_attr;
    logic [SIZE_W-1:0]         sprite_size;
    logic signed [DELTA_W-1:0] delta;
  } req_t;

  typedef struct packed {
    logic                    status;
    logic                    write_valid;
    logic [LINK_W-1:0]       slot;
    logic [LINK_W-1:0]       next_link;
    logic signed [POS_W-1:0] out_pos_x;
    logic signed [POS_W-1:0] out_pos_y;
    logic [ATTR_W-1:0]       out_attr;
    logic [SIZE_W-1:0]       out_size;
    logic                    last;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_FIRST,
    ST_FIRST_WR,
    ST_FIRST_EMIT,
    ST_ADD_WALK,
    ST_ADD_WR_NEW,
    ST_ADD_WR_LINK,
    ST_ADD_REREAD,
    ST_ADD_EMIT_NEW,
    ST_ADD_EMIT_PRED,
    ST_DROP_WALK,
    ST_DROP_FETCH,
    ST_DROP_REREAD,
    ST_DROP_EMIT,
    ST_SCROLL_WALK,
    ST_EMIT_FULL,
    ST_EMIT_ACK
  } state_t;

  // Read address source
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_NEXT,
    RD_REP
  } rd_sel_t;

  // Link write data source for a predecessor update
  typedef enum logic {
    LINK_NEW_SLOT,
    LINK_FETCHED
  } link_sel_t;

  // Result format
  typedef enum logic [1:0] {
    RES_NEW,
    RES_ENTRY,
    RES_FULL,
    RES_ACK
  } res_sel_t;

  typedef struct packed {
    logic      load_item;
    logic      clear_walk;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      advance;
    logic      set_rep;
    logic      mark_new;
    logic      mark_first;
    logic      set_started;
    logic      wr_new;
    logic      wr_link;
    link_sel_t link_sel;
    logic      wr_scroll;
    logic      out_load;
    res_sel_t  res_sel;
    logic      out_last;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic nz;
    logic last_step;
    logic gap;
    logic room;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

/* design/slla_dpath.sv */
// Datapath: entry memories, link valid bits, walk registers and the result register.
module slla_dpath #(
  parameter int TABLE_ENTRIES = slla_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  slla_pkg::req_t req,
  input  slla_pkg::cmd_t cmd,
  output slla_pkg::stat_t stat,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output slla_pkg::rsp_t rsp
);
  import slla_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W:0]   ENTRIES   = (IDX_W + 1)'(TABLE_ENTRIES);
  localparam logic [LINK_W:0]  ENTRIES_L = (LINK_W + 1)'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_ENTRIES - 1);

  logic [LINK_W-1:0]        link_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] link_vld;
  logic [POS_W-1:0]         x_mem    [TABLE_ENTRIES];
  logic [POS_W-1:0]         y_mem    [TABLE_ENTRIES];
  logic [ATTR_W-1:0]        attr_mem [TABLE_ENTRIES];
  logic [SIZE_W-1:0]        size_mem [TABLE_ENTRIES];

  req_t              item;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  steps;
  logic [IDX_W-1:0]  rep;
  logic [IDX_W-1:0]  new_slot;
  logic [LINK_W-1:0] new_link;
  logic              started;

  logic [LINK_W-1:0] rd_link;
  logic [POS_W-1:0]  rd_x;
  logic [POS_W-1:0]  rd_y;
  logic [ATTR_W-1:0] rd_attr;
  logic [SIZE_W-1:0] rd_size;

  logic [IDX_W-1:0]  nxt;
  logic [IDX_W:0]    cur_inc;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  lk_addr;
  logic [LINK_W-1:0] lk_data;
  logic              lk_we;
  logic              x_we;
  logic              y_we;
  logic              vertical;
  logic [POS_W-1:0]  delta_ext;
  logic [POS_W-1:0]  x_wdata;
  logic [POS_W-1:0]  y_wdata;
  logic              out_free;
  rsp_t              rsp_next;

  // A link outside the table ends the chain
  assign nxt     = ({1'b0, rd_link} < ENTRIES_L) ? rd_link[IDX_W-1:0] : '0;
  assign cur_inc = {1'b0, cur} + (IDX_W + 1)'(1);

  assign out_free = !rsp_valid || !rsp_stall;

  assign stat.started   = started;
  assign stat.nz        = (nxt != '0);
  assign stat.last_step = (steps == LAST_STEP);
  assign stat.gap       = ({1'b0, nxt} != cur_inc);
  assign stat.room      = (cur_inc < ENTRIES);
  assign stat.hit       = (LINK_W'(nxt) == item.entry_index);
  assign stat.out_free  = out_free;

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_NEXT: rd_addr = nxt;
      RD_REP:  rd_addr = rep;
      default: rd_addr = '0;
    endcase
  end

  assign lk_we   = cmd.wr_new || cmd.wr_link;
  assign lk_addr = cmd.wr_new ? new_slot : rep;
  always_comb begin
    if (cmd.wr_new) begin
      lk_data = new_link;
    end else if (cmd.link_sel == LINK_NEW_SLOT) begin
      lk_data = LINK_W'(new_slot);
    end else begin
      lk_data = rd_link;
    end
  end

  assign vertical  = (item.op == OP_VSCROLL);
  assign delta_ext = {{(POS_W - DELTA_W){item.delta[DELTA_W-1]}}, item.delta};
  assign wr_addr   = cmd.wr_new ? new_slot : cur;
  assign x_we      = cmd.wr_new || (cmd.wr_scroll && !vertical);
  assign y_we      = cmd.wr_new || (cmd.wr_scroll && vertical);
  assign x_wdata   = cmd.wr_new ? item.new_pos_x : rd_x + delta_ext;
  assign y_wdata   = cmd.wr_new ? item.new_pos_y : rd_y + delta_ext;

  // Registered read port shared by all entry memories
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_link <= link_vld[rd_addr] ? link_mem[rd_addr] : '0;
      rd_x    <= x_mem[rd_addr];
      rd_y    <= y_mem[rd_addr];
      rd_attr <= attr_mem[rd_addr];
      rd_size <= size_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_addr] <= lk_data;
    end
  end

  // Unwritten links read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (lk_we) begin
      link_vld[lk_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[wr_addr] <= x_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (y_we) begin
      y_mem[wr_addr] <= y_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      attr_mem[wr_addr] <= item.sprite_attr;
      size_mem[wr_addr] <= item.sprite_size;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= req;
    end
    if (cmd.clear_walk) begin
      cur   <= '0;
      steps <= '0;
    end else if (cmd.advance) begin
      cur   <= nxt;
      steps <= steps + IDX_W'(1);
    end
    if (cmd.set_rep) begin
      rep <= cur;
    end
    if (cmd.mark_new) begin
      if (cmd.mark_first) begin
        new_slot <= '0;
        new_link <= '0;
      end else begin
        new_slot <= cur_inc[IDX_W-1:0];
        new_link <= LINK_W'(nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (cmd.set_started) begin
      started <= 1'b1;
    end
  end

  always_comb begin
    rsp_next      = '0;
    rsp_next.last = cmd.out_last;
    case (cmd.res_sel)
      RES_NEW: begin
        rsp_next.write_valid = 1'b1;
        rsp_next.slot        = LINK_W'(new_slot);
        rsp_next.next_link   = new_link;
        rsp_next.out_pos_x   = item.new_pos_x;
        rsp_next.out_pos_y   = item.new_pos_y;
        rsp_next.out_attr    = item.sprite_attr;
        rsp_next.out_size    = item.sprite_size;
      end
      RES_ENTRY: begin
        rsp_next.write_valid = 1'b1;
        rsp_next.slot        = LINK_W'(rep);
        rsp_next.next_link   = rd_link;
        rsp_next.out_pos_x   = rd_x;
        rsp_next.out_pos_y   = rd_y;
        rsp_next.out_attr    = rd_attr;
        rsp_next.out_size    = rd_size;
      end
      RES_FULL: begin
        rsp_next.status = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* design/slla_ctrl.sv */
// Controller: sequences the list walks, table writes and result emission.
module slla_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  slla_pkg::op_t   op,
  input  slla_pkg::stat_t stat,
  output slla_pkg::cmd_t  cmd,
  output logic            busy
);
  import slla_pkg::*;

  state_t state;
  state_t state_next;

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (op)
            OP_ADD:  state_next = stat.started ? ST_ADD_WALK : ST_ADD_FIRST;
            OP_DROP: state_next = ST_DROP_WALK;
            default: state_next = ST_SCROLL_WALK;
          endcase
        end
      end
      ST_ADD_FIRST:  state_next = ST_FIRST_WR;
      ST_FIRST_WR:   state_next = ST_FIRST_EMIT;
      ST_FIRST_EMIT: if (stat.out_free) state_next = ST_IDLE;
      ST_ADD_WALK: begin
        if (!stat.nz) begin
          state_next = stat.room ? ST_ADD_WR_NEW : ST_EMIT_FULL;
        end else if (stat.gap) begin
          state_next = ST_ADD_WR_NEW;
        end else if (stat.last_step) begin
          state_next = ST_EMIT_FULL;
        end
      end
      ST_ADD_WR_NEW:    state_next = ST_ADD_WR_LINK;
      ST_ADD_WR_LINK:   state_next = ST_ADD_REREAD;
      ST_ADD_REREAD:    state_next = ST_ADD_EMIT_NEW;
      ST_ADD_EMIT_NEW:  if (stat.out_free) state_next = ST_ADD_EMIT_PRED;
      ST_ADD_EMIT_PRED: if (stat.out_free) state_next = ST_IDLE;
      ST_DROP_WALK: begin
        if (!stat.nz) begin
          state_next = ST_DROP_REREAD;
        end else if (stat.hit) begin
          state_next = ST_DROP_FETCH;
        end else if (stat.last_step) begin
          state_next = ST_DROP_REREAD;
        end
      end
      ST_DROP_FETCH:  state_next = ST_DROP_REREAD;
      ST_DROP_REREAD: state_next = ST_DROP_EMIT;
      ST_DROP_EMIT:   if (stat.out_free) state_next = ST_IDLE;
      ST_SCROLL_WALK: if (!stat.nz || stat.last_step) state_next = ST_EMIT_ACK;
      ST_EMIT_FULL:   if (stat.out_free) state_next = ST_IDLE;
      ST_EMIT_ACK:    if (stat.out_free) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_ZERO;
    cmd.link_sel = LINK_NEW_SLOT;
    cmd.res_sel  = RES_ACK;
    case (state)
      ST_IDLE: begin
        // Take the item and fetch the list head
        if (req_valid) begin
          cmd.load_item  = 1'b1;
          cmd.clear_walk = 1'b1;
          cmd.rd_en      = 1'b1;
        end
      end
      ST_ADD_FIRST: begin
        cmd.mark_new    = 1'b1;
        cmd.mark_first  = 1'b1;
        cmd.set_started = 1'b1;
      end
      ST_FIRST_WR: cmd.wr_new = 1'b1;
      ST_FIRST_EMIT: begin
        cmd.out_load = stat.out_free;
        cmd.res_sel  = RES_NEW;
        cmd.out_last = 1'b1;
      end
      ST_ADD_WALK: begin
        if ((!stat.nz && stat.room) || (stat.nz && stat.gap)) begin
          cmd.mark_new = 1'b1;
          cmd.set_rep  = 1'b1;
        end else if (stat.nz && !stat.last_step) begin
          cmd.advance = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_NEXT;
        end
      end
      ST_ADD_WR_NEW: cmd.wr_new = 1'b1;
      ST_ADD_WR_LINK: begin
        cmd.wr_link  = 1'b1;
        cmd.link_sel = LINK_NEW_SLOT;
      end
      ST_ADD_REREAD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_REP;
      end
      ST_ADD_EMIT_NEW: begin
        cmd.out_load = stat.out_free;
        cmd.res_sel  = RES_NEW;
      end
      ST_ADD_EMIT_PRED: begin
        cmd.out_load = stat.out_free;
        cmd.res_sel  = RES_ENTRY;
        cmd.out_last = 1'b1;
      end
      ST_DROP_WALK: begin
        if (!stat.nz) begin
          cmd.set_rep = 1'b1;
        end else if (stat.hit) begin
          // Fetch the dropped entry for its link
          cmd.set_rep = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_NEXT;
        end else if (stat.last_step) begin
          cmd.set_rep = 1'b1;
        end else begin
          cmd.advance = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_NEXT;
        end
      end
      ST_DROP_FETCH: begin
        cmd.wr_link  = 1'b1;
        cmd.link_sel = LINK_FETCHED;
      end
      ST_DROP_REREAD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_REP;
      end
      ST_DROP_EMIT: begin
        cmd.out_load = stat.out_free;
        cmd.res_sel  = RES_ENTRY;
        cmd.out_last = 1'b1;
      end
      ST_SCROLL_WALK: begin
        cmd.wr_scroll = 1'b1;
        if (stat.nz && !stat.last_step) begin
          cmd.advance = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_NEXT;
        end
      end
      ST_EMIT_FULL: begin
        cmd.out_load = stat.out_free;
        cmd.res_sel  = RES_FULL;
        cmd.out_last = 1'b1;
      end
      ST_EMIT_ACK: begin
        cmd.out_load = stat.out_free;
        cmd.res_sel  = RES_ACK;
        cmd.out_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/sprite_link_list_allocator.sv */
// Sprite link-list allocator top level: controller plus datapath.
// One item at a time; the list walk visits one entry per cycle (memory read port).
// Per item: the first add writes slot 0; a later add walks to a free slot, writes the new entry and
// links its predecessor to it; a drop relinks past the hit entry; a scroll updates each entry.
// A new item is taken while the final result of the previous one waits.
// Reset clears the controller, the list-started flag and all link valid bits at once.
module sprite_link_list_allocator #(
  parameter int TABLE_ENTRIES = slla_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  slla_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output slla_pkg::rsp_t rsp
);
  import slla_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  assign req_stall = busy;

  slla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .op        (req.op),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  slla_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

/* design/slla_checker.sv */
// Port-level checker for the sprite link-list allocator, bound to the top level.
module slla_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input slla_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input slla_pkg::rsp_t rsp
);
  import slla_pkg::*;

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Accepting a transfer makes the block busy
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input not stalled after a transfer");

  // A leading result is always a new entry beyond the head, mid-item
  a_lead_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.write_valid && !rsp.status && rsp.slot != '0 && req_stall)
    else $error("malformed leading result");

  // A full report carries no table write and closes the item
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.last && !rsp.write_valid)
    else $error("malformed full report");

endmodule

bind sprite_link_list_allocator slla_checker u_slla_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
